>>> design/aqd_pkg.sv
`timescale 1ns / 1ps

package aqd_pkg;

   localparam int MaxQueues   = 64;
   localparam int QueueBits   = 6;
   localparam int CountBits   = 7;
   localparam int MaskBits    = 64;
   localparam int HandleBits  = 64;
   localparam int PrioBits    = 32;
   localparam int SeqBits     = 32;
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;

   // fraction of the golden ratio, 32 fraction bits, rounded down
   localparam logic [SeqBits-1:0] PhiFrac = 32'h9E37_79B9;

   // register index of queue_count
   localparam logic CsrQueueCount = 1'b0;

   typedef struct packed {
      logic               start;
      logic [SeqBits-1:0] dividend;
      logic [CountBits-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [CountBits-1:0] remainder;
   } mod_rsp_type;

   function automatic logic [QueueBits-1:0] lowest_bit(input logic [MaskBits-1:0] v);
      logic [QueueBits-1:0] idx;
      idx = '0;
      for (int i = MaskBits - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = QueueBits'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [CountBits-1:0] count_bits(input logic [MaskBits-1:0] v);
      logic [CountBits-1:0] n;
      n = '0;
      for (int i = 0; i < MaskBits; i++) begin
         n = n + CountBits'(v[i]);
      end
      return n;
   endfunction

endpackage

>>> design/aqd_if.sv
`timescale 1ns / 1ps

interface aqd_req_if;
   logic                                valid;
   logic                                ready;
   logic [aqd_pkg::MaskBits-1:0]        affinity_mask;
   logic [aqd_pkg::MaskBits-1:0]        empty_flags;
   logic [aqd_pkg::HandleBits-1:0]      task_handle;
   logic [aqd_pkg::PrioBits-1:0]        task_priority;

   modport source (output valid, affinity_mask, empty_flags, task_handle, task_priority,
                   input ready);
   modport sink   (input valid, affinity_mask, empty_flags, task_handle, task_priority,
                   output ready);
endinterface

interface aqd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [aqd_pkg::QueueBits-1:0]       queue_index;
   logic                                picked_by_sequence;
   logic [aqd_pkg::HandleBits-1:0]      handle_out;
   logic [aqd_pkg::PrioBits-1:0]        priority_out;

   modport source (output valid, queue_index, picked_by_sequence, handle_out, priority_out,
                   input ready);
   modport sink   (input valid, queue_index, picked_by_sequence, handle_out, priority_out,
                   output ready);
endinterface

>>> design/aqd_mod_unit.sv
`timescale 1ns / 1ps

// Restoring remainder, one quotient bit per cycle.
module aqd_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  aqd_pkg::mod_req_type mod_req,
   output aqd_pkg::mod_rsp_type mod_rsp
);

   typedef enum logic {
      MOD_IDLE,
      MOD_RUN
   } state_type;

   state_type                         state_ff, state_in;
   logic [aqd_pkg::SeqBits-1:0]       dividend_ff, dividend_in;
   logic [aqd_pkg::CountBits-1:0]     divisor_ff, divisor_in;
   logic [aqd_pkg::CountBits-1:0]     rem_ff, rem_in;
   logic [4:0]                        step_ff, step_in;
   logic                              done_ff, done_in;
   logic [aqd_pkg::CountBits:0]       shifted;

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      done_in     = 1'b0;
      shifted     = {rem_ff, dividend_ff[aqd_pkg::SeqBits-1]};
      case (state_ff)
         MOD_IDLE: begin
            if (mod_req.start) begin
               dividend_in = mod_req.dividend;
               divisor_in  = mod_req.divisor;
               rem_in      = '0;
               step_in     = '0;
               state_in    = MOD_RUN;
            end
         end
         MOD_RUN: begin
            if (shifted >= {1'b0, divisor_ff}) begin
               rem_in = aqd_pkg::CountBits'(shifted - {1'b0, divisor_ff});
            end else begin
               rem_in = aqd_pkg::CountBits'(shifted);
            end
            dividend_in = {dividend_ff[aqd_pkg::SeqBits-2:0], 1'b0};
            step_in     = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               done_in  = 1'b1;
               state_in = MOD_IDLE;
            end
         end
         default: begin
            state_in = MOD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MOD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

>>> design/aqd_csr.sv
`timescale 1ns / 1ps

// Register file: queue_count only.
module aqd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [aqd_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [aqd_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [aqd_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [aqd_pkg::CountBits-1:0]    queue_count
);

   logic [aqd_pkg::CountBits-1:0] queue_count_ff, queue_count_in;
   logic                          reg_index;

   assign reg_index  = csr_paddr[aqd_pkg::CsrAddrBits-1];
   assign csr_pready = 1'b1;

   always_comb begin
      queue_count_in = queue_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == aqd_pkg::CsrQueueCount)) begin
         queue_count_in = csr_pwdata[aqd_pkg::CountBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_count_ff <= aqd_pkg::CountBits'(aqd_pkg::MaxQueues);
      end else begin
         queue_count_ff <= queue_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == aqd_pkg::CsrQueueCount) begin
         csr_prdata = {{(aqd_pkg::CsrDataBits - aqd_pkg::CountBits){1'b0}}, queue_count_ff};
      end
   end

   assign queue_count = queue_count_ff;

endmodule

>>> design/affinity_queue_dispatcher.sv
`timescale 1ns / 1ps
// The empty-queue path goes PICK -> OUTPUT; the sequence path also runs MULT, ADD, MOD and
// CLEAR, waiting for the bit-serial remainder unit and skipping k set bits (k = 0..63).
// One transaction at a time: a new request is accepted only after the previous result has
// been handed to the output register and the FSM is back in IDLE. A result
// held in the output register does not block the next accept, only the next hand-off.
// Reset (synchronous, active high): queue_count = 64, sequence counter = 0, no result held.

module affinity_queue_dispatcher (
   input  logic                             clock,
   input  logic                             reset,
   aqd_req_if.sink                          req_bus,
   aqd_rsp_if.source                        rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [aqd_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [aqd_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [aqd_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                             csr_pready
);

   // Flow per transaction:
   //   IDLE   latch masks, limit affinity to the queues in use
   //   PICK   empty allowed queue -> lowest one; else popcount and go to the sequence
   //   MULT   counter * phi fraction, upper half kept
   //   ADD    counter + that half, start remainder by popcount
   //   MOD    wait for remainder unit
   //   CLEAR  drop lowest set bit k times, then take the lowest remaining
   //   OUTPUT hand result to the output register when it is free
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_MULT,
      ST_ADD,
      ST_MOD,
      ST_CLEAR,
      ST_OUTPUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [aqd_pkg::MaskBits-1:0]       allowed_ff, allowed_in;
   logic [aqd_pkg::MaskBits-1:0]       ready_ff, ready_in;
   logic [aqd_pkg::HandleBits-1:0]     handle_ff, handle_in;
   logic [aqd_pkg::PrioBits-1:0]       priority_ff, priority_in;
   logic [aqd_pkg::CountBits-1:0]      pop_ff, pop_in;
   logic [aqd_pkg::SeqBits-1:0]        prod_hi_ff, prod_hi_in;
   logic [aqd_pkg::QueueBits-1:0]      k_ff, k_in;
   logic [aqd_pkg::QueueBits-1:0]      queue_ff, queue_in;
   logic                               picked_ff, picked_in;
   logic [aqd_pkg::SeqBits-1:0]        counter_ff, counter_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [aqd_pkg::QueueBits-1:0]      rsp_queue_ff, rsp_queue_in;
   logic                               rsp_picked_ff, rsp_picked_in;
   logic [aqd_pkg::HandleBits-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [aqd_pkg::PrioBits-1:0]       rsp_priority_ff, rsp_priority_in;

   logic [aqd_pkg::CountBits-1:0]      queue_count;
   logic [aqd_pkg::CountBits-1:0]      qc_clamped;
   logic [aqd_pkg::MaskBits-1:0]       in_use;
   logic [aqd_pkg::MaskBits-1:0]       affinity_in_use;
   logic [2*aqd_pkg::SeqBits-1:0]      product;
   aqd_pkg::mod_req_type               mod_req;
   aqd_pkg::mod_rsp_type               mod_rsp;

   aqd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .queue_count (queue_count)
   );

   aqd_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // queue count forced into 1..64
   always_comb begin
      qc_clamped = queue_count;
      if (queue_count == '0) begin
         qc_clamped = aqd_pkg::CountBits'(1);
      end else if (queue_count > aqd_pkg::CountBits'(aqd_pkg::MaxQueues)) begin
         qc_clamped = aqd_pkg::CountBits'(aqd_pkg::MaxQueues);
      end
   end

   assign in_use = {aqd_pkg::MaskBits{1'b1}} >>
                   (aqd_pkg::CountBits'(aqd_pkg::MaxQueues) - qc_clamped);
   assign affinity_in_use = req_bus.affinity_mask & in_use;

   // one 32x32 multiply, registered before the add
   assign product = (2*aqd_pkg::SeqBits)'(counter_ff) *
                    (2*aqd_pkg::SeqBits)'(aqd_pkg::PhiFrac);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      allowed_in      = allowed_ff;
      ready_in        = ready_ff;
      handle_in       = handle_ff;
      priority_in     = priority_ff;
      pop_in          = pop_ff;
      prod_hi_in      = prod_hi_ff;
      k_in            = k_ff;
      queue_in        = queue_ff;
      picked_in       = picked_ff;
      counter_in      = counter_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = counter_ff + prod_hi_ff;
      mod_req.divisor  = pop_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_queue_in    = rsp_queue_ff;
      rsp_picked_in   = rsp_picked_ff;
      rsp_handle_in   = rsp_handle_ff;
      rsp_priority_in = rsp_priority_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               // no usable affinity bit means every queue in use
               allowed_in  = (affinity_in_use == '0) ? in_use : affinity_in_use;
               ready_in    = ((affinity_in_use == '0) ? in_use : affinity_in_use) &
                             req_bus.empty_flags;
               handle_in   = req_bus.task_handle;
               priority_in = req_bus.task_priority;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            if (ready_ff != '0) begin
               queue_in  = aqd_pkg::lowest_bit(ready_ff);
               picked_in = 1'b0;
               state_in  = ST_OUTPUT;
            end else begin
               pop_in   = aqd_pkg::count_bits(allowed_ff);
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_hi_in = product[2*aqd_pkg::SeqBits-1:aqd_pkg::SeqBits];
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            mod_req.start = 1'b1;
            state_in      = ST_MOD;
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               // remainder < popcount <= 64
               k_in     = mod_rsp.remainder[aqd_pkg::QueueBits-1:0];
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (k_ff == '0) begin
               queue_in   = aqd_pkg::lowest_bit(allowed_ff);
               picked_in  = 1'b1;
               counter_in = counter_ff + aqd_pkg::SeqBits'(1);
               state_in   = ST_OUTPUT;
            end else begin
               allowed_in = allowed_ff & (allowed_ff - aqd_pkg::MaskBits'(1));
               k_in       = k_ff - aqd_pkg::QueueBits'(1);
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_queue_in    = queue_ff;
               rsp_picked_in   = picked_ff;
               rsp_handle_in   = handle_ff;
               rsp_priority_in = priority_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      allowed_ff      <= allowed_in;
      ready_ff        <= ready_in;
      handle_ff       <= handle_in;
      priority_ff     <= priority_in;
      pop_ff          <= pop_in;
      prod_hi_ff      <= prod_hi_in;
      k_ff            <= k_in;
      queue_ff        <= queue_in;
      picked_ff       <= picked_in;
      rsp_queue_ff    <= rsp_queue_in;
      rsp_picked_ff   <= rsp_picked_in;
      rsp_handle_ff   <= rsp_handle_in;
      rsp_priority_ff <= rsp_priority_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.queue_index        = rsp_queue_ff;
   assign rsp_bus.picked_by_sequence = rsp_picked_ff;
   assign rsp_bus.handle_out         = rsp_handle_ff;
   assign rsp_bus.priority_out       = rsp_priority_ff;

endmodule
